/* design/steque_ring_buffer_defines.svh */
// Assertion macros for the steque ring buffer design file.
`ifndef STEQUE_RING_BUFFER_DEFINES_SVH
`define STEQUE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/steque_pkg.sv */
`timescale 1ns / 1ps

package steque_pkg;

    typedef enum logic [2:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_PUSH    = 3'd1,
        CMD_POP     = 3'd2,
        CMD_PEEK    = 3'd3,
        CMD_CYCLE   = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage

/* design/steque_ring_buffer.sv */
`timescale 1ns / 1ps
// Steque: a stack-ended queue held in a circular buffer of DEPTH words.
// Command channel: drive i_command and i_item_in with i_start high; the
// command is taken at the edge where i_start is high and o_busy is low.
// Commands: enqueue at the back, push at the front, pop or peek the front,
// cycle the front word to the back, clear.
// Result channel: o_done is registered from the execute state and is high
// for one cycle, with o_item_out, o_item_count, o_is_empty and o_status.
// The receiver has no way to stall; it must sample the result on o_done.
// The block takes no new command until the current one has executed. The
// word store is a synchronous RAM with a registered read; the front word is
// read in the accept cycle and the read-modify-write runs in the following
// execute cycle, during which o_busy is high.
// A new command may be accepted in the cycle where o_done is high.
// Reset (synchronous, active low) empties the store: head, tail and count
// go to zero. Word contents are not cleared; only occupied slots are read.
// Pop or peek on empty reports underflow, enqueue or push on full reports
// overflow and drops the word; neither changes the store.
module steque_ring_buffer #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [2:0]       i_command,
    input  logic [31:0]      i_item_in,
    output logic             o_done,
    output logic [31:0]      o_item_out,
    output logic [CNT_W-1:0] o_item_count,
    output logic             o_is_empty,
    output logic [1:0]       o_status
);

`include "steque_ring_buffer_defines.svh"

    localparam int PTR_W = $clog2(DEPTH);

    steque_pkg::t_state  r_state, n_state;
    steque_pkg::t_cmd    r_cmd;
    logic [ITEM_WIDTH-1:0] r_item;

    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rd_data;

    logic                r_done, n_done;
    logic [31:0]         r_item_out, n_item_out;
    steque_pkg::t_status r_status, n_status;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [PTR_W-1:0]      head_inc, head_dec, tail_inc;

    assign accept   = i_start && (r_state == steque_pkg::ST_IDLE);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    assign head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
    assign tail_inc = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // Word store: one write port, one registered read of the front slot.
    // The front word read in the accept cycle is current, since writes
    // happen only in the execute cycle and a command never follows directly.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= steque_pkg::t_cmd'(i_command);
            r_item <= ITEM_WIDTH'(i_item_in);
        end
        r_item_out <= n_item_out;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_done     = 1'b0;
        n_item_out = '0;
        n_status   = steque_pkg::STATUS_OK;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = r_item;

        unique case (r_state)
            steque_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = steque_pkg::ST_EXEC;
                end
            end
            steque_pkg::ST_EXEC: begin
                n_state = steque_pkg::ST_IDLE;
                n_done  = 1'b1;
                unique case (r_cmd)
                    steque_pkg::CMD_ENQUEUE: begin
                        if (is_full) begin
                            n_status = steque_pkg::STATUS_OVERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            n_tail  = tail_inc;
                            n_count = r_count + 1'b1;
                        end
                    end
                    steque_pkg::CMD_PUSH: begin
                        if (is_full) begin
                            n_status = steque_pkg::STATUS_OVERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = head_dec;
                            n_head  = head_dec;
                            n_count = r_count + 1'b1;
                        end
                    end
                    steque_pkg::CMD_POP: begin
                        if (is_empty) begin
                            n_status = steque_pkg::STATUS_UNDERFLOW;
                        end else begin
                            n_item_out = 32'(r_rd_data);
                            n_head     = head_inc;
                            n_count    = r_count - 1'b1;
                        end
                    end
                    steque_pkg::CMD_PEEK: begin
                        if (is_empty) begin
                            n_status = steque_pkg::STATUS_UNDERFLOW;
                        end else begin
                            n_item_out = 32'(r_rd_data);
                        end
                    end
                    steque_pkg::CMD_CYCLE: begin
                        // copy the front word to the back slot, advance both ends
                        if (!is_empty) begin
                            wr_en   = 1'b1;
                            wr_data = r_rd_data;
                            n_head  = head_inc;
                            n_tail  = tail_inc;
                        end
                    end
                    steque_pkg::CMD_CLEAR: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = steque_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= steque_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    assign o_busy       = (r_state == steque_pkg::ST_EXEC);
    assign o_done       = r_done;
    assign o_item_out   = r_item_out;
    assign o_item_count = r_count;
    assign o_is_empty   = is_empty;
    assign o_status     = r_status;

    `STQ_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, accept, o_busy && !accept,
        "accepted command did not enter execute")
    `STQ_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, o_busy, o_done,
        "execute cycle gave no result strobe")
    `STQ_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "occupancy beyond depth")
    `STQ_ASSERT_IMPLY(a_ends_meet, i_clk, i_rst_n, is_empty || is_full, r_head == r_tail,
        "head and tail differ on empty or full store")
    `STQ_ASSERT_IMPLY(a_underflow_zero, i_clk, i_rst_n,
        o_done && (r_status == steque_pkg::STATUS_UNDERFLOW), o_item_out == '0 && o_is_empty,
        "underflow result carries a word or a nonempty store")

endmodule

/* verif/steque_ring_buffer_tb.sv */
`timescale 1ns / 1ps

module steque_ring_buffer_tb;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 5000;
    localparam int SHOWN_ERRS  = 10;

    // codes outside the command set; the block must leave the store alone
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [31:0]      word;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic [1:0]       status;
    } t_steque_reply;

    class t_steque_shadow;
        logic [31:0]   slots [DEPTH];
        int            head;
        int            tail;
        int            fill;
        t_steque_reply replies_due [$];
        int            mismatches;
        int            checked;
        int            peak_fill;
        int            cmd_seen [8];
        int            status_seen [4];

        function void note_command(logic [2:0] cmd, logic [31:0] word);
            t_steque_reply r;
            r.word   = '0;
            r.status = steque_pkg::STATUS_OK;
            case (cmd)
                steque_pkg::CMD_ENQUEUE: begin
                    if (fill == DEPTH) begin
                        r.status = steque_pkg::STATUS_OVERFLOW;
                    end else begin
                        slots[tail] = word;
                        tail = (tail + 1) % DEPTH;
                        fill++;
                    end
                end
                steque_pkg::CMD_PUSH: begin
                    if (fill == DEPTH) begin
                        r.status = steque_pkg::STATUS_OVERFLOW;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = word;
                        fill++;
                    end
                end
                steque_pkg::CMD_POP: begin
                    if (fill == 0) begin
                        r.status = steque_pkg::STATUS_UNDERFLOW;
                    end else begin
                        r.word = slots[head];
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                steque_pkg::CMD_PEEK: begin
                    if (fill == 0) r.status = steque_pkg::STATUS_UNDERFLOW;
                    else r.word = slots[head];
                end
                steque_pkg::CMD_CYCLE: begin
                    // move the front word to the back; count is unchanged
                    if (fill != 0) begin
                        slots[tail] = slots[head];
                        tail = (tail + 1) % DEPTH;
                        head = (head + 1) % DEPTH;
                    end
                end
                steque_pkg::CMD_CLEAR: begin
                    head = 0;
                    tail = 0;
                    fill = 0;
                end
                default: begin
                end
            endcase
            r.count = fill[CNT_W-1:0];
            r.empty = (fill == 0);
            replies_due.push_back(r);
            cmd_seen[cmd]++;
            status_seen[r.status]++;
            if (fill > peak_fill) peak_fill = fill;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= SHOWN_ERRS) $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_reply(logic [31:0] word, logic [CNT_W-1:0] count,
                                  logic empty, logic [1:0] status);
            t_steque_reply want;
            if (replies_due.size() == 0) begin
                flag($sformatf("result with no command waiting: word %h count %0d",
                               word, count));
                return;
            end
            want = replies_due.pop_front();
            checked++;
            if (word !== want.word || count !== want.count || empty !== want.empty ||
                status !== want.status) begin
                flag($sformatf({"expected word %h count %0d empty %0b status %0d, ",
                                "got %h %0d %0b %0d"},
                               want.word, want.count, want.empty, want.status,
                               word, count, empty, status));
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             i_start   = 1'b0;
    logic [2:0]       i_command = steque_pkg::CMD_PEEK;
    logic [31:0]      i_item_in = '0;
    logic             o_busy;
    logic             o_done;
    logic [31:0]      o_item_out;
    logic [CNT_W-1:0] o_item_count;
    logic             o_is_empty;
    logic [1:0]       o_status;

    t_steque_shadow shadow = new();
    int             quiet_cycles = 0;
    int             idle_pct = 0;

    steque_ring_buffer #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (32)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_command    (i_command),
        .i_item_in    (i_item_in),
        .o_done       (o_done),
        .o_item_out   (o_item_out),
        .o_item_count (o_item_count),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check the result before noting a command taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            shadow.check_reply(o_item_out, o_item_count, o_is_empty, o_status);
        end
        if (i_rst_n && i_start && !o_busy) begin
            shadow.note_command(i_command, i_item_in);
        end
        if (i_rst_n && (o_done || (i_start && !o_busy))) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("steque_ring_buffer_tb: FAIL");
        $finish;
    end

    task automatic send_command(logic [2:0] cmd, logic [31:0] word);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_command <= cmd;
        i_item_in <= word;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // hold off new commands until every result is back
    task automatic drain_replies();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // lean toward growth, shrinkage or a balanced mix
    function automatic logic [2:0] pick_command(int lean);
        int roll;
        int cut [7];
        roll = $urandom_range(99);
        case (lean)
            0:       cut = '{35, 70, 80, 87, 95, 97, 98};
            1:       cut = '{12, 24, 70, 82, 92, 95, 97};
            default: cut = '{25, 50, 72, 82, 94, 96, 98};
        endcase
        if (roll < cut[0]) return steque_pkg::CMD_ENQUEUE;
        if (roll < cut[1]) return steque_pkg::CMD_PUSH;
        if (roll < cut[2]) return steque_pkg::CMD_POP;
        if (roll < cut[3]) return steque_pkg::CMD_PEEK;
        if (roll < cut[4]) return steque_pkg::CMD_CYCLE;
        if (roll < cut[5]) return steque_pkg::CMD_CLEAR;
        if (roll < cut[6]) return CMD_SPARE6;
        return CMD_SPARE7;
    endfunction

    initial begin
        int phase_idle [4];
        int lean;
        phase_idle = '{0, 77, 31, 0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, spare codes, wrap of the front slot, clear
        send_command(steque_pkg::CMD_POP, 32'h0);
        send_command(steque_pkg::CMD_PEEK, 32'h0);
        send_command(steque_pkg::CMD_CYCLE, 32'h0);
        send_command(CMD_SPARE6, 32'hFFFF_FFFF);
        send_command(CMD_SPARE7, 32'hFFFF_FFFF);
        send_command(steque_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
        send_command(steque_pkg::CMD_PUSH, 32'h0000_0000);
        send_command(steque_pkg::CMD_PEEK, 32'h1234_5678);
        send_command(steque_pkg::CMD_CYCLE, 32'h0);
        send_command(steque_pkg::CMD_PEEK, 32'h0);
        send_command(CMD_SPARE6, 32'h0);
        send_command(steque_pkg::CMD_POP, 32'h0);
        send_command(steque_pkg::CMD_POP, 32'h0);
        send_command(steque_pkg::CMD_POP, 32'h0);
        send_command(steque_pkg::CMD_ENQUEUE, 32'hA5A5_5A5A);
        send_command(steque_pkg::CMD_PUSH, 32'h5A5A_A5A5);
        send_command(steque_pkg::CMD_CLEAR, 32'h0);
        send_command(steque_pkg::CMD_PEEK, 32'h0);
        send_command(steque_pkg::CMD_CLEAR, 32'h0);
        drain_replies();

        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            lean = 0;
            for (int n = 0; n < 120; n++) begin
                if (n % 24 == 0) lean = $urandom_range(2);
                send_command(pick_command(lean), pick_word());
            end
            drain_replies();
        end

        repeat (8) @(posedge i_clk);

        $display({"covered %0d enqueue, %0d push, %0d pop, %0d peek, %0d cycle, ",
                  "%0d clear, %0d spare"},
                 shadow.cmd_seen[steque_pkg::CMD_ENQUEUE],
                 shadow.cmd_seen[steque_pkg::CMD_PUSH],
                 shadow.cmd_seen[steque_pkg::CMD_POP],
                 shadow.cmd_seen[steque_pkg::CMD_PEEK],
                 shadow.cmd_seen[steque_pkg::CMD_CYCLE],
                 shadow.cmd_seen[steque_pkg::CMD_CLEAR],
                 shadow.cmd_seen[CMD_SPARE6] + shadow.cmd_seen[CMD_SPARE7]);
        $display({"%0d results checked, %0d overflow, %0d underflow, ",
                  "peak count %0d, %0d mismatches"},
                 shadow.checked, shadow.status_seen[steque_pkg::STATUS_OVERFLOW],
                 shadow.status_seen[steque_pkg::STATUS_UNDERFLOW], shadow.peak_fill,
                 shadow.mismatches);
        if (shadow.pending() != 0) begin
            $display("%0d results never arrived", shadow.pending());
        end
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("steque_ring_buffer_tb: PASS");
        end else begin
            $display("steque_ring_buffer_tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/steque_pkg.sv
design/steque_ring_buffer.sv
verif/steque_ring_buffer_tb.sv
